@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while rst is high.
`define SERB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("serb assertion failed");

// Clocked property, checked through reset as well.
`define SERB_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("serb assertion failed");

`endif

@@ hw/rtl/serb_pkg.sv @@
package serb_pkg;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // port groups (address bits 9:4)
   localparam logic [5:0] GRP_MONO  = 6'h3B;
   localparam logic [5:0] GRP_ATTR  = 6'h3C;
   localparam logic [5:0] GRP_COLOR = 6'h3D;

   localparam logic [9:0] ALIAS_XOR = 10'h060;

   localparam logic [9:0] PORT_MISC     = 10'h3C2;
   localparam logic [9:0] PORT_SEQ_IDX  = 10'h3C4;
   localparam logic [9:0] PORT_SEQ_DATA = 10'h3C5;
   localparam logic [9:0] PORT_GFX_IDX  = 10'h3CE;
   localparam logic [9:0] PORT_GFX_DATA = 10'h3CF;
   localparam logic [9:0] PORT_CRT_IDX  = 10'h3D4;
   localparam logic [9:0] PORT_CRT_DATA = 10'h3D5;
   localparam logic [9:0] PORT_BANK_D8  = 10'h3D8;
   localparam logic [9:0] PORT_BANK_D9  = 10'h3D9;

   localparam logic [3:0] SEQ_OLD_NEW  = 4'hB;
   localparam logic [3:0] SEQ_POWER_UP = 4'hC;
   localparam logic [3:0] SEQ_CTRL_TWO = 4'hD;
   localparam logic [3:0] SEQ_MODE_CTL = 4'hE;

   localparam logic [3:0] GFX_BANK_ALT = 4'hE;
   localparam logic [3:0] GFX_BANK_CTL = 4'hF;

   localparam logic [5:0] CRT_PROTECT_TOP = 6'h07;
   localparam logic [5:0] CRT_FREE_LO     = 6'h0E;
   localparam logic [5:0] CRT_FREE_HI     = 6'h10;
   localparam logic [5:0] CRT_PROTECT_REG = 6'h11;

   localparam logic [7:0] ID_CODE  = 8'h33;
   localparam logic [7:0] BANK_XOR = 8'h02;

   typedef struct packed {
      logic       action;
      logic [9:0] port_address;
      logic [7:0] write_data;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [4:0] read_bank_number;
      logic [4:0] write_bank_number;
      logic       wide_vram;
      logic       timing_change;
      logic       passed_through;
   } result_type;

endpackage

@@ hw/rtl/serb_ram.sv @@
module serb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/serb_regs.sv @@
module serb_regs #(
   parameter int CRTC_ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  serb_pkg::item_type   item,
   output serb_pkg::result_type result
);

   import serb_pkg::*;

   localparam int AW = $clog2(CRTC_ENTRIES);
   localparam logic [6:0] ENTRY_LIMIT = 7'(CRTC_ENTRIES);

   logic       color_ff, color_in;
   logic [3:0] seq_index_ff, seq_index_in;
   logic [3:0] gfx_index_ff, gfx_index_in;
   logic [5:0] crtc_index_ff, crtc_index_in;
   logic [7:0] seq_mode_ff, seq_mode_in;
   logic [7:0] gfx_alt_ff, gfx_alt_in;
   logic [7:0] gfx_ctl_ff, gfx_ctl_in;
   logic       old_mode_ff, old_mode_in;
   logic [7:0] old_ctl_two_ff, old_ctl_two_in;
   logic [7:0] new_ctl_two_ff, new_ctl_two_in;
   logic [7:0] d8_ff, d8_in;
   logic [7:0] d9_ff, d9_in;
   logic [4:0] read_bank_ff, read_bank_in;
   logic [4:0] write_bank_ff, write_bank_in;
   logic       protect_ff, protect_in;

   // CRTC file: valid bits plus a one-entry forward around the registered read
   logic [CRTC_ENTRIES-1:0] valid_ff, valid_in;
   logic                    hit_ff, rvalid_ff;
   logic [7:0]              hit_data_ff;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr, ram_raddr;
   logic [7:0]              ram_q, entry;
   logic                    idx_in_range, next_in_range;

   logic [9:0] eff_port;
   logic [5:0] grp;
   logic       relevant;
   logic [7:0] v, v_x;

   serb_ram #(.WIDTH(8), .DEPTH(CRTC_ENTRIES)) u_crtc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (v),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign idx_in_range  = {1'b0, crtc_index_ff} < ENTRY_LIMIT;
   assign next_in_range = {1'b0, crtc_index_in} < ENTRY_LIMIT;
   assign ram_waddr     = crtc_index_ff[AW-1:0];
   assign ram_raddr     = crtc_index_in[AW-1:0];
   assign entry         = hit_ff ? hit_data_ff : (rvalid_ff ? ram_q : 8'h00);

   assign v   = item.write_data;
   assign v_x = item.write_data ^ BANK_XOR;
   assign grp = item.port_address[9:4];
   assign relevant = (grp == GRP_MONO) || (grp == GRP_ATTR) || (grp == GRP_COLOR);

   always_comb begin
      color_in       = color_ff;
      seq_index_in   = seq_index_ff;
      gfx_index_in   = gfx_index_ff;
      crtc_index_in  = crtc_index_ff;
      seq_mode_in    = seq_mode_ff;
      gfx_alt_in     = gfx_alt_ff;
      gfx_ctl_in     = gfx_ctl_ff;
      old_mode_in    = old_mode_ff;
      old_ctl_two_in = old_ctl_two_ff;
      new_ctl_two_in = new_ctl_two_ff;
      d8_in          = d8_ff;
      d9_in          = d9_ff;
      read_bank_in   = read_bank_ff;
      write_bank_in  = write_bank_ff;
      protect_in     = protect_ff;
      valid_in       = valid_ff;
      ram_we         = 1'b0;
      result         = '0;

      eff_port = item.port_address;
      if (((grp == GRP_MONO) || (grp == GRP_COLOR)) && !color_ff) begin
         eff_port = item.port_address ^ ALIAS_XOR;
      end

      if (fire && relevant) begin
         if (item.action == ACT_WRITE) begin
            result.passed_through = 1'b1;
            unique case (eff_port)
               PORT_MISC:    color_in = v[0];
               PORT_SEQ_IDX: seq_index_in = v[3:0];
               PORT_GFX_IDX: gfx_index_in = v[3:0];
               PORT_SEQ_DATA: begin
                  // sequencer 0xC and old control 1 are write-only; nothing reads them
                  unique case (seq_index_ff)
                     SEQ_OLD_NEW:  old_mode_in = 1'b1;
                     SEQ_CTRL_TWO: begin
                        if (old_mode_ff) old_ctl_two_in = v;
                        else new_ctl_two_in = v;
                     end
                     SEQ_MODE_CTL: begin
                        result.passed_through = 1'b0;
                        if (!old_mode_ff) begin
                           seq_mode_in   = v_x;
                           write_bank_in = {1'b0, v_x[3:0]};
                           if (!gfx_ctl_ff[0]) read_bank_in = {1'b0, v_x[3:0]};
                        end
                     end
                     default: ;
                  endcase
               end
               PORT_GFX_DATA: begin
                  if (gfx_index_ff == GFX_BANK_ALT) begin
                     gfx_alt_in = v_x;
                     if (gfx_ctl_ff[0]) read_bank_in = {1'b0, v_x[3:0]};
                  end else if (gfx_index_ff == GFX_BANK_CTL) begin
                     gfx_ctl_in    = v;
                     read_bank_in  = {1'b0, v[0] ? gfx_alt_ff[3:0] : seq_mode_ff[3:0]};
                     write_bank_in = {1'b0, seq_mode_ff[3:0]};
                  end
               end
               PORT_CRT_IDX: begin
                  result.passed_through = 1'b0;
                  crtc_index_in = v[5:0];
               end
               PORT_CRT_DATA: begin
                  result.passed_through = 1'b0;
                  if (!((crtc_index_ff <= CRT_PROTECT_TOP) && protect_ff) && idx_in_range)
                  begin
                     ram_we = 1'b1;
                     valid_in[ram_waddr] = 1'b1;
                     if (crtc_index_ff == CRT_PROTECT_REG) protect_in = v[7];
                     result.timing_change = (entry != v) &&
                        ((crtc_index_ff < CRT_FREE_LO) || (crtc_index_ff > CRT_FREE_HI));
                  end
               end
               PORT_BANK_D8: begin
                  result.passed_through = 1'b0;
                  d8_in = v;
                  if (gfx_ctl_ff[2]) begin
                     write_bank_in = v[4:0];
                     if (!gfx_ctl_ff[0]) read_bank_in = v[4:0];
                  end
               end
               PORT_BANK_D9: begin
                  result.passed_through = 1'b0;
                  d9_in = v;
                  if (gfx_ctl_ff[0] && gfx_ctl_ff[2]) read_bank_in = v[4:0];
               end
               default: ;
            endcase
         end else begin
            result.passed_through = 1'b1;
            unique case (eff_port)
               PORT_SEQ_DATA: begin
                  if (seq_index_ff == SEQ_OLD_NEW) begin
                     old_mode_in = 1'b0;
                     result.read_data = ID_CODE;
                     result.passed_through = 1'b0;
                  end else if (seq_index_ff == SEQ_CTRL_TWO) begin
                     result.read_data = old_mode_ff ? old_ctl_two_ff : new_ctl_two_ff;
                     result.passed_through = 1'b0;
                  end
               end
               PORT_CRT_IDX: begin
                  result.read_data = {2'b00, crtc_index_ff};
                  result.passed_through = 1'b0;
               end
               PORT_CRT_DATA: begin
                  result.read_data = idx_in_range ? entry : 8'h00;
                  result.passed_through = 1'b0;
               end
               PORT_BANK_D8: begin
                  result.read_data = d8_ff;
                  result.passed_through = 1'b0;
               end
               PORT_BANK_D9: begin
                  result.read_data = d9_ff;
                  result.passed_through = 1'b0;
               end
               default: ;
            endcase
         end
      end

      result.read_bank_number  = read_bank_in;
      result.write_bank_number = write_bank_in;
      result.wide_vram         = old_ctl_two_in[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff       <= 1'b0;
         seq_index_ff   <= '0;
         gfx_index_ff   <= '0;
         crtc_index_ff  <= '0;
         seq_mode_ff    <= '0;
         gfx_alt_ff     <= '0;
         gfx_ctl_ff     <= '0;
         old_mode_ff    <= 1'b0;
         old_ctl_two_ff <= '0;
         new_ctl_two_ff <= '0;
         d8_ff          <= '0;
         d9_ff          <= '0;
         read_bank_ff   <= '0;
         write_bank_ff  <= '0;
         protect_ff     <= 1'b0;
         valid_ff       <= '0;
         hit_ff         <= 1'b0;
         rvalid_ff      <= 1'b0;
      end else begin
         color_ff       <= color_in;
         seq_index_ff   <= seq_index_in;
         gfx_index_ff   <= gfx_index_in;
         crtc_index_ff  <= crtc_index_in;
         seq_mode_ff    <= seq_mode_in;
         gfx_alt_ff     <= gfx_alt_in;
         gfx_ctl_ff     <= gfx_ctl_in;
         old_mode_ff    <= old_mode_in;
         old_ctl_two_ff <= old_ctl_two_in;
         new_ctl_two_ff <= new_ctl_two_in;
         d8_ff          <= d8_in;
         d9_ff          <= d9_in;
         read_bank_ff   <= read_bank_in;
         write_bank_ff  <= write_bank_in;
         protect_ff     <= protect_in;
         valid_ff       <= valid_in;
         // entry under the next index: forward a same-cycle write
         hit_ff         <= ram_we && (ram_waddr == ram_raddr);
         rvalid_ff      <= next_in_range && valid_in[ram_raddr];
      end
      hit_data_ff <= v;
   end

endmodule

@@ hw/rtl/svga_extended_register_banking_core.sv @@
// Extended register banking core of a display adapter, driven by I/O port accesses.
// Input channel req_*: one port read or write per transfer (req_tuser = 1 for write).
// Result channel rsp_*: exactly one result per input transfer, in order: read data,
// current read/write bank, VRAM size flag, CRTC timing-change flag and a flag
// telling that the access belongs to the standard VGA core or RAMDAC.
// An input register feeds the decode and register update, and a result register
// holds the answer that rsp_tvalid marks as valid.
// Throughput is one access per cycle while rsp_tready stays high; the CRTC file is a
// 64x8 RAM whose registered read is fetched ahead under the next CRTC index, with a
// write forward, so back-to-back CRTC writes and reads run at full rate.
// When rsp_tready is low the result register holds; one more access can wait in
// the input register, after which req_tready drops until the result is taken.
// Reset (synchronous, active high) clears the control registers and valid bits, so
// every CRTC entry reads as zero, and empties both registers; no clearing pass is needed.
module svga_extended_register_banking_core #(
   parameter int CRTC_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // port_address[9:0], write_data[17:10], zero pad
   input  logic        req_tuser,  // action (0 read, 1 write)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_data[7:0], read_bank_number[12:8],
                                   // write_bank_number[17:13], wide_vram[18],
                                   // timing_change[19], passed_through[20], zero pad
);

   import serb_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   result_type res;
   logic       advance, fire, req_xfer;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   serb_regs #(.CRTC_ENTRIES(CRTC_ENTRIES)) u_regs (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_xfer) begin
         in_item_ff.action       <= req_tuser;
         in_item_ff.port_address <= req_tdata[9:0];
         in_item_ff.write_data   <= req_tdata[17:10];
      end
      if (fire) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_res_ff.passed_through,
                        out_res_ff.timing_change,
                        out_res_ff.wide_vram,
                        out_res_ff.write_bank_number,
                        out_res_ff.read_bank_number,
                        out_res_ff.read_data};

endmodule

@@ hw/rtl/serb_checker.sv @@
`include "assert_macros.svh"

module serb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic rsp_stall, no_data, timing_hit, local_only, pass_hit;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign no_data    = (rsp_tdata[7:0] == 8'h00);
   assign timing_hit = rsp_tvalid && rsp_tdata[19];
   assign local_only = !rsp_tdata[20] && no_data;
   assign pass_hit   = rsp_tvalid && rsp_tdata[20];

   // a stalled result stays put
   `SERB_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))

   // reset empties the result register
   `SERB_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // timing change only comes from a CRTC data write, which is handled locally
   `SERB_ASSERT(a_timing_local, clock, reset, timing_hit |-> local_only)

   // passed-through accesses never return local data
   `SERB_ASSERT(a_pass_no_data, clock, reset, pass_hit |-> no_data)

endmodule

bind svga_extended_register_banking_core serb_checker u_serb_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import serb_pkg::*;

   localparam int CRT_DEPTH = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // port_address[9:0], write_data[17:10], zero pad
   logic        req_tuser = 1'b0; // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // read_data[7:0], read_bank_number[12:8],
                                 // write_bank_number[17:13], wide_vram[18],
                                 // timing_change[19], passed_through[20], zero pad

   // register image of the block, advanced once per accepted access
   logic       color_mode = 1'b0;
   logic [3:0] seq_sel = '0;
   logic [3:0] gfx_sel = '0;
   logic [5:0] crt_sel = '0;
   logic [7:0] crt_regs [0:CRT_DEPTH-1];
   logic [7:0] power_up_reg = '0;
   logic [7:0] mode_ctl_reg = '0;
   logic [7:0] bank_alt_reg = '0;
   logic [7:0] bank_ctl_reg = '0;
   logic       old_mode = 1'b0;
   logic [7:0] old_ctl_one = '0;
   logic [7:0] old_ctl_two = '0;
   logic [7:0] new_ctl_two = '0;
   logic [7:0] d8_latch = '0;
   logic [7:0] d9_latch = '0;
   logic [4:0] rd_bank = '0;
   logic [4:0] wr_bank = '0;

   result_type expected_results [$];
   int fail_count = 0;
   int items_sent = 0;
   int quiet_cycles = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int rx_wait = 0;
   logic steady = 1'b0;

   svga_extended_register_banking_core #(.CRTC_ENTRIES(CRT_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // updates the register image and returns what the block should answer
   function automatic result_type model_access(input logic act, input logic [9:0] addr,
                                               input logic [7:0] wd);
      result_type r;
      logic [9:0] p;
      logic [5:0] grp;
      r = '0;
      p = addr;
      grp = addr[9:4];
      if (grp == GRP_MONO || grp == GRP_ATTR || grp == GRP_COLOR) begin
         if (grp != GRP_ATTR && !color_mode) p = p ^ ALIAS_XOR;
         r.passed_through = 1'b1;
         if (act == ACT_WRITE) begin
            case (p)
               PORT_MISC: color_mode = wd[0];
               PORT_SEQ_IDX: seq_sel = wd[3:0];
               PORT_GFX_IDX: gfx_sel = wd[3:0];
               PORT_SEQ_DATA: begin
                  case (seq_sel)
                     SEQ_OLD_NEW: old_mode = 1'b1;
                     SEQ_POWER_UP: if (mode_ctl_reg[7]) power_up_reg = wd;
                     SEQ_CTRL_TWO: begin
                        if (old_mode) old_ctl_two = wd;
                        else new_ctl_two = wd;
                     end
                     SEQ_MODE_CTL: begin
                        r.passed_through = 1'b0;
                        if (old_mode) begin
                           old_ctl_one = wd;
                        end else begin
                           mode_ctl_reg = wd ^ BANK_XOR;
                           wr_bank = {1'b0, mode_ctl_reg[3:0]};
                           if (!bank_ctl_reg[0]) rd_bank = wr_bank;
                        end
                     end
                     default: ;
                  endcase
               end
               PORT_GFX_DATA: begin
                  if (gfx_sel == GFX_BANK_ALT) begin
                     bank_alt_reg = wd ^ BANK_XOR;
                     if (bank_ctl_reg[0]) rd_bank = {1'b0, bank_alt_reg[3:0]};
                  end else if (gfx_sel == GFX_BANK_CTL) begin
                     bank_ctl_reg = wd;
                     rd_bank = {1'b0, wd[0] ? bank_alt_reg[3:0] : mode_ctl_reg[3:0]};
                     wr_bank = {1'b0, mode_ctl_reg[3:0]};
                  end
               end
               PORT_CRT_IDX: begin
                  r.passed_through = 1'b0;
                  crt_sel = wd[5:0];
               end
               PORT_CRT_DATA: begin
                  r.passed_through = 1'b0;
                  // low timing registers are locked while the protect bit is set
                  if (!(crt_sel <= CRT_PROTECT_TOP && crt_regs[CRT_PROTECT_REG][7])) begin
                     if (crt_regs[crt_sel] != wd &&
                         (crt_sel < CRT_FREE_LO || crt_sel > CRT_FREE_HI))
                        r.timing_change = 1'b1;
                     crt_regs[crt_sel] = wd;
                  end
               end
               PORT_BANK_D8: begin
                  r.passed_through = 1'b0;
                  d8_latch = wd;
                  if (bank_ctl_reg[2]) begin
                     wr_bank = wd[4:0];
                     if (!bank_ctl_reg[0]) rd_bank = wd[4:0];
                  end
               end
               PORT_BANK_D9: begin
                  r.passed_through = 1'b0;
                  d9_latch = wd;
                  if (bank_ctl_reg[0] && bank_ctl_reg[2]) rd_bank = wd[4:0];
               end
               default: ;
            endcase
         end else begin
            case (p)
               PORT_SEQ_DATA: begin
                  if (seq_sel == SEQ_OLD_NEW) begin
                     old_mode = 1'b0;
                     r.read_data = ID_CODE;
                     r.passed_through = 1'b0;
                  end else if (seq_sel == SEQ_CTRL_TWO) begin
                     r.read_data = old_mode ? old_ctl_two : new_ctl_two;
                     r.passed_through = 1'b0;
                  end
               end
               PORT_CRT_IDX: begin
                  r.read_data = {2'b00, crt_sel};
                  r.passed_through = 1'b0;
               end
               PORT_CRT_DATA: begin
                  r.read_data = crt_regs[crt_sel];
                  r.passed_through = 1'b0;
               end
               PORT_BANK_D8: begin
                  r.read_data = d8_latch;
                  r.passed_through = 1'b0;
               end
               PORT_BANK_D9: begin
                  r.read_data = d9_latch;
                  r.passed_through = 1'b0;
               end
               default: ;
            endcase
         end
      end
      r.read_bank_number = rd_bank;
      r.write_bank_number = wr_bank;
      r.wide_vram = old_ctl_two[4];
      return r;
   endfunction

   // address under which a color-group port is reached in the current mode
   function automatic logic [9:0] live_port(input logic [9:0] p);
      if (p[9:4] != GRP_ATTR && !color_mode) return p ^ ALIAS_XOR;
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_access(input logic act, input logic [9:0] addr, input logic [7:0] wd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {6'd0, wd, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(model_access(act, addr, wd));
      items_sent++;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("read_data", want.read_data, rsp_tdata[7:0]);
            check_field("read_bank_number", want.read_bank_number, rsp_tdata[12:8]);
            check_field("write_bank_number", want.write_bank_number, rsp_tdata[17:13]);
            check_field("wide_vram", want.wide_vram, rsp_tdata[18]);
            check_field("timing_change", want.timing_change, rsp_tdata[19]);
            check_field("passed_through", want.passed_through, rsp_tdata[20]);
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         rx_wait <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait <= rx_wait - 1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rx_wait <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("svga_extended_register_banking_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_port_ranges();
      send_access(ACT_READ, 10'h000, 8'h00);
      send_access(ACT_WRITE, 10'h3FF, 8'hFF);
   endtask

   // mono aliasing, then CRTC protection and the timing-change rule in color mode
   task automatic test_crtc_file();
      send_access(ACT_READ, PORT_CRT_IDX ^ ALIAS_XOR, 8'h00);
      send_access(ACT_WRITE, PORT_CRT_IDX, {2'b00, CRT_PROTECT_REG});
      send_access(ACT_WRITE, PORT_MISC, 8'h01);
      send_access(ACT_WRITE, PORT_CRT_IDX, {2'b00, CRT_PROTECT_REG});
      send_access(ACT_WRITE, PORT_CRT_DATA, 8'h80);
      send_access(ACT_WRITE, PORT_CRT_IDX, 8'h03);
      send_access(ACT_WRITE, PORT_CRT_DATA, 8'h55);
      send_access(ACT_WRITE, PORT_CRT_IDX, {2'b00, CRT_FREE_HI} - 8'd1);
      send_access(ACT_WRITE, PORT_CRT_DATA, 8'hAA);
   endtask

   task automatic test_sequencer_regs();
      send_access(ACT_WRITE, PORT_SEQ_IDX, {4'hF, SEQ_OLD_NEW});
      send_access(ACT_READ, PORT_SEQ_DATA, 8'h00);
      send_access(ACT_WRITE, PORT_SEQ_DATA, 8'h00);
      send_access(ACT_WRITE, PORT_SEQ_IDX, {4'h0, SEQ_CTRL_TWO});
      send_access(ACT_WRITE, PORT_SEQ_DATA, 8'hFF);
      send_access(ACT_READ, PORT_SEQ_DATA, 8'h00);
      send_access(ACT_WRITE, PORT_SEQ_IDX, {4'h0, SEQ_POWER_UP});
      send_access(ACT_READ, PORT_SEQ_DATA, 8'h00);
   endtask

   task automatic test_bank_selects();
      send_access(ACT_WRITE, PORT_GFX_IDX, {4'h0, GFX_BANK_CTL});
      send_access(ACT_WRITE, PORT_GFX_DATA, 8'h05);
      send_access(ACT_WRITE, live_port(PORT_BANK_D8), 8'hFF);
      send_access(ACT_WRITE, live_port(PORT_BANK_D9), 8'hEE);
      send_access(ACT_WRITE, PORT_GFX_IDX, {4'h0, GFX_BANK_ALT});
      send_access(ACT_WRITE, PORT_GFX_DATA, 8'h00);
   endtask

   // index write, data write and data read back to back across the CRTC file
   task automatic test_full_rate();
      logic [7:0] idx;
      steady = 1'b1;
      repeat (33) begin
         idx = 8'($urandom_range(0, CRT_DEPTH - 1));
         send_access(ACT_WRITE, live_port(PORT_CRT_IDX), idx);
         send_access(ACT_WRITE, live_port(PORT_CRT_DATA), 8'($urandom));
         send_access(ACT_READ, live_port(PORT_CRT_DATA), 8'($urandom));
      end
      steady = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      steady = 1'b1;
      holds_asked++;
      repeat (20) begin
         send_access(ACT_WRITE, live_port(PORT_CRT_IDX), 8'($urandom));
         send_access(ACT_READ, live_port(PORT_CRT_DATA), 8'($urandom));
      end
      steady = 1'b0;
   endtask

   task automatic test_random_traffic(input int count);
      int stop_at;
      int pick;
      logic [7:0] val;
      stop_at = items_sent + count;
      steady = 1'b0;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 199) == 0) steady = ~steady;
         pick = $urandom_range(0, 99);
         val = 8'($urandom);
         if (pick < 20) begin
            if ($urandom_range(0, 4) != 0)
               val[3:0] = 4'($urandom_range(SEQ_OLD_NEW, SEQ_MODE_CTL));
            send_access(ACT_WRITE, PORT_SEQ_IDX, val);
            repeat ($urandom_range(1, 2))
               send_access(1'($urandom_range(0, 1)), PORT_SEQ_DATA, 8'($urandom));
         end else if (pick < 35) begin
            if ($urandom_range(0, 4) != 0)
               val[3:0] = $urandom_range(0, 1) ? GFX_BANK_ALT : GFX_BANK_CTL;
            send_access(ACT_WRITE, PORT_GFX_IDX, val);
            send_access(1'($urandom_range(0, 1)), PORT_GFX_DATA, 8'($urandom));
         end else if (pick < 65) begin
            case ($urandom_range(0, 9))
               0, 1: val[5:0] = CRT_PROTECT_REG;
               2, 3, 4, 5: val[5:0] = 6'($urandom_range(0, 24));
               default: ;
            endcase
            send_access(ACT_WRITE, live_port(PORT_CRT_IDX), val);
            repeat ($urandom_range(1, 3))
               send_access(1'($urandom_range(0, 1)), live_port(PORT_CRT_DATA),
                           8'($urandom));
         end else if (pick < 80) begin
            send_access(1'($urandom_range(0, 1)),
                        live_port($urandom_range(0, 1) ? PORT_BANK_D9 : PORT_BANK_D8), val);
         end else if (pick < 84) begin
            send_access(ACT_WRITE, PORT_MISC, val);
         end else if (pick < 92) begin
            send_access(1'($urandom_range(0, 1)),
                        10'($urandom_range({GRP_MONO, 4'h0}, {GRP_COLOR, 4'hF})), val);
         end else begin
            send_access(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)), val);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      foreach (crt_regs[i]) crt_regs[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_port_ranges();
      test_crtc_file();
      test_sequencer_regs();
      test_bank_selects();
      test_backpressure();
      test_full_rate();
      test_random_traffic(1490);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("svga_extended_register_banking_core regression: pass");
      else
         $display("svga_extended_register_banking_core regression: fail");
      $finish;
   end

endmodule
